// File: sv/rcr_pkg.sv
// Shared types, constants and the sine table function of the raycast column renderer.
`timescale 1ns / 1ps

package rcr_pkg;

    localparam int DEFAULT_SCREEN_WIDTH     = 190;
    localparam int DEFAULT_SCREEN_HEIGHT    = 52;
    localparam int DEFAULT_SINE_TABLE_DEPTH = 256;

    localparam int FOV_BAM      = 10923;
    localparam int HALF_FOV_BAM = 5461;
    localparam int STEP_Q       = 205;
    localparam int DEPTH_Q      = 32768;
    localparam int NEAR_Q       = 16384;
    localparam int HORIZON_Q    = 4096;
    localparam int EDGE_COS2    = 1073634999;

    localparam logic [14:0] PLAYER_X_RESET = 15'd24576;
    localparam logic [14:0] PLAYER_Y_RESET = 15'd10240;

    // Ceiling divider: dividend covers H*|d - 4096|; divisor covers 2*d.
    localparam int DIV_DW = 22;
    localparam int DIV_VW = 17;
    localparam int MUL_W  = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [6:0] CH_SPACE = 7'd32;
    localparam logic [6:0] CH_TILDE = 7'd126;
    localparam logic [6:0] CH_MINUS = 7'd45;
    localparam logic [6:0] CH_HASH  = 7'd35;
    localparam logic [6:0] CH_X     = 7'd120;
    localparam logic [6:0] CH_DOT   = 7'd46;

    typedef enum logic [2:0] {
        CFG_MAP0,
        CFG_MAP1,
        CFG_MAP2,
        CFG_MAP3,
        CFG_PLAYER_X,
        CFG_PLAYER_Y,
        CFG_PLAYER_ANGLE
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_RAY,
        OP_SIN,
        OP_COS,
        OP_EY,
        OP_MX,
        OP_MY,
        OP_EXIT,
        OP_HIT,
        OP_STEP,
        OP_SQX,
        OP_SQY,
        OP_LEN,
        OP_NX,
        OP_NY,
        OP_NUM,
        OP_NEXT,
        OP_SQ,
        OP_RHS,
        OP_EDGE,
        OP_CEIL,
        OP_NCEIL,
        OP_ROW
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ANG_WAIT,
        ST_SIN,
        ST_COS,
        ST_EY,
        ST_MX,
        ST_MY,
        ST_MCHK,
        ST_SQX,
        ST_SQY,
        ST_LEN,
        ST_NX,
        ST_NY,
        ST_NUM,
        ST_TEST,
        ST_SQW,
        ST_RHSW,
        ST_CEIL,
        ST_CEIL_WAIT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic mul_busy;
        logic ray_exit;
        logic wall;
        logic depth_done;
        logic k_last;
        logic skip;
        logic lhs_gt;
        logic out_last;
    } status_t;

    // Quarter-wave odd polynomial sine of a binary angle, Q2.14, truncated.
    function automatic logic signed [15:0] sine_of_bam(input int b);
        longint quad;
        longint r;
        longint x;
        longint x2;
        longint t;
        longint s;
        quad = (b >> 14) & 3;
        r = b & 16'h3FFF;
        if (quad % 2 == 1)
            r = 16384 - r;
        x = (r * 25736) >>> 14;
        x2 = (x * x) >>> 14;
        t = 16384 - x2 / 42;
        t = 16384 - ((x2 * t) >>> 14) / 20;
        t = 16384 - ((x2 * t) >>> 14) / 6;
        s = (x * t) >>> 14;
        if (s > 16384)
            s = 16384;
        if (quad >= 2)
            s = -s;
        return 16'(s);
    endfunction

endpackage

// File: sv/rcr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rcr_div #(
    parameter int DW = rcr_pkg::DIV_DW,
    parameter int VW = rcr_pkg::DIV_VW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);
    import rcr_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;
    logic [VW:0]   shifted;
    logic [VW:0]   diff;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = CW'(DW);
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[VW])
            begin
                rem_next = diff[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// File: sv/rcr_mul.sv
// Sequential unsigned multiplier, two multiplier bits per cycle.
`timescale 1ns / 1ps

module rcr_mul #(
    parameter int W = rcr_pkg::MUL_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           busy,
    output logic [2*W-1:0] result
);
    import rcr_pkg::*;

    localparam int STEPS = (W + 1) / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [2*W-1:0]   a_reg, a_next;
    logic [2*W-1:0]   acc_reg, acc_next;
    logic [2*STEPS-1:0] b_reg, b_next;
    logic [2*W-1:0]   pp0;
    logic [2*W-1:0]   pp1;

    assign pp0 = b_reg[0] ? a_reg : '0;
    assign pp1 = b_reg[1] ? {a_reg[2*W-2:0], 1'b0} : '0;

    always_comb
    begin
        cnt_next = cnt_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (start)
        begin
            cnt_next = CW'(STEPS);
            a_next   = {{W{1'b0}}, a};
            b_next   = (2*STEPS)'(b);
            acc_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            acc_next = acc_reg + pp0 + pp1;
            a_next   = {a_reg[2*W-3:0], 2'b00};
            b_next   = {2'b00, b_reg[2*STEPS-1:2]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy   = (cnt_reg != '0);
    assign result = acc_reg;

endmodule

// File: sv/rcr_ctrl.sv
// Controller state machine that sequences the ray cast, edge test and row output.
`timescale 1ns / 1ps

module rcr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             column_valid,
    output logic             column_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  rcr_pkg::status_t status,
    output rcr_pkg::cmd_t    cmd
);
    import rcr_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (column_valid) state_next = ST_ANG_WAIT;
            ST_ANG_WAIT:  if (!status.div_busy) state_next = ST_SIN;
            ST_SIN:       state_next = ST_COS;
            ST_COS:       state_next = ST_EY;
            ST_EY:        state_next = ST_MX;
            ST_MX:        state_next = ST_MY;
            ST_MY:        state_next = ST_MCHK;
            ST_MCHK:
            begin
                priority if (status.ray_exit)
                    state_next = ST_CEIL;
                else if (status.wall)
                    state_next = ST_SQX;
                else if (status.depth_done)
                    state_next = ST_CEIL;
                else
                    state_next = ST_MX;
            end
            ST_SQX:       state_next = ST_SQY;
            ST_SQY:       state_next = ST_LEN;
            ST_LEN:       state_next = status.k_last ? ST_NX : ST_SQX;
            ST_NX:        state_next = ST_NY;
            ST_NY:        state_next = ST_NUM;
            ST_NUM:       state_next = ST_TEST;
            ST_TEST:
            begin
                if (status.skip)
                    state_next = status.k_last ? ST_CEIL : ST_NX;
                else
                    state_next = ST_SQW;
            end
            ST_SQW:       if (!status.mul_busy) state_next = ST_RHSW;
            ST_RHSW:
            begin
                if (!status.mul_busy)
                begin
                    if (status.lhs_gt || status.k_last)
                        state_next = ST_CEIL;
                    else
                        state_next = ST_NX;
                end
            end
            ST_CEIL:      state_next = ST_CEIL_WAIT;
            ST_CEIL_WAIT: if (!status.div_busy) state_next = ST_EMIT;
            ST_EMIT:      if (result_ready && status.out_last) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op       = OP_NONE;
        column_ready = 1'b0;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                column_ready = 1'b1;
                if (column_valid) cmd.op = OP_LOAD;
            end
            ST_ANG_WAIT:  if (!status.div_busy) cmd.op = OP_RAY;
            ST_SIN:       cmd.op = OP_SIN;
            ST_COS:       cmd.op = OP_COS;
            ST_EY:        cmd.op = OP_EY;
            ST_MX:        cmd.op = OP_MX;
            ST_MY:        cmd.op = OP_MY;
            ST_MCHK:
            begin
                priority if (status.ray_exit)
                    cmd.op = OP_EXIT;
                else if (status.wall)
                    cmd.op = OP_HIT;
                else if (status.depth_done)
                    cmd.op = OP_NONE;
                else
                    cmd.op = OP_STEP;
            end
            ST_SQX:       cmd.op = OP_SQX;
            ST_SQY:       cmd.op = OP_SQY;
            ST_LEN:       cmd.op = OP_LEN;
            ST_NX:        cmd.op = OP_NX;
            ST_NY:        cmd.op = OP_NY;
            ST_NUM:       cmd.op = OP_NUM;
            ST_TEST:      cmd.op = status.skip ? OP_NEXT : OP_SQ;
            ST_SQW:       if (!status.mul_busy) cmd.op = OP_RHS;
            ST_RHSW:
            begin
                if (!status.mul_busy)
                    cmd.op = status.lhs_gt ? OP_EDGE : OP_NEXT;
            end
            ST_CEIL:      cmd.op = OP_CEIL;
            ST_CEIL_WAIT: if (!status.div_busy) cmd.op = OP_NCEIL;
            ST_EMIT:
            begin
                result_valid = 1'b1;
                if (result_ready) cmd.op = OP_ROW;
            end
            default:      cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: sv/rcr_dp.sv
// Datapath: configuration, sine table, ray march, corner edge test and row shading.
`timescale 1ns / 1ps

module rcr_dp #(
    parameter int SCREEN_WIDTH     = rcr_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT    = rcr_pkg::DEFAULT_SCREEN_HEIGHT,
    parameter int SINE_TABLE_DEPTH = rcr_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rcr_pkg::cmd_t                  cmd,
    output rcr_pkg::status_t               status,
    input  logic                           cfg_we,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [7:0]                     column,
    output logic [7:0]                     column_echo,
    output logic [5:0]                     row,
    output logic [6:0]                     char_code,
    output logic [15:0]                    wall_distance,
    output logic                           last_row
);
    import rcr_pkg::*;

    localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
    localparam int NW    = DIV_DW + 2;
    localparam logic signed [NW-1:0] H_S = NW'(SCREEN_HEIGHT);
    localparam logic [15:0] RAY_BIAS = 16'(65536 - HALF_FOV_BAM);

    // Configuration registers
    logic [255:0] map_reg, map_next;
    logic [14:0]  px_reg, px_next;
    logic [14:0]  py_reg, py_next;
    logic [15:0]  pa_reg, pa_next;

    // Working registers
    logic [7:0]               col_reg, col_next;
    logic [15:0]              ray_reg, ray_next;
    logic signed [15:0]       rom_q_reg, rom_q_next;
    logic signed [15:0]       ex_reg, ex_next;
    logic signed [15:0]       ey_reg, ey_next;
    logic [15:0]              d_reg, d_next;
    logic signed [35:0]       prod_reg, prod_next;
    logic signed [35:0]       acc_reg, acc_next;
    logic signed [35:0]       num_reg, num_next;
    logic signed [18:0]       posx_reg, posx_next;
    logic [3:0]               cx_reg, cx_next;
    logic [3:0]               cy_reg, cy_next;
    logic [1:0]               k_reg, k_next;
    logic [1:0]               far_reg, far_next;
    logic [31:0]              far_len_reg, far_len_next;
    logic [31:0]              len_reg [4];
    logic [31:0]              len_next [4];
    logic [63:0]              lhs_reg, lhs_next;
    logic                     edge_reg, edge_next;
    logic                     neg_reg, neg_next;
    logic signed [DIV_DW:0]   nceil_reg, nceil_next;
    logic [5:0]               y_reg, y_next;

    // Sine table, a constant array read through a registered port
    logic signed [15:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar i = 0; i < SINE_TABLE_DEPTH; i++)
    begin : g_rom
        localparam int B = (i * 65536) / SINE_TABLE_DEPTH;
        assign sine_rom[i] = sine_of_bam(B);
    end

    // Angle offset of every column code, column*FOV/SCREEN_WIDTH, as a constant table
    logic [15:0] col_ang [256];

    for (genvar i = 0; i < 256; i++)
    begin : g_col_ang
        assign col_ang[i] = 16'((i * FOV_BAM) / SCREEN_WIDTH);
    end

    logic [16+IDX_W:0] sin_scaled;
    logic [16+IDX_W:0] cos_scaled;
    logic [15:0]       ray_cos;
    logic [IDX_W-1:0]  rom_addr;

    assign ray_cos    = ray_reg + 16'd16384;
    assign sin_scaled = (17+IDX_W)'(ray_reg) * (17+IDX_W)'(SINE_TABLE_DEPTH);
    assign cos_scaled = (17+IDX_W)'(ray_cos) * (17+IDX_W)'(SINE_TABLE_DEPTH);
    assign rom_addr   = (cmd.op == OP_SIN) ? sin_scaled[16 +: IDX_W] : cos_scaled[16 +: IDX_W];

    // Ceiling divider and wide multiplier
    logic              div_start;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    logic              div_busy;
    logic [DIV_DW-1:0] div_q;
    logic              mul_start;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic              mul_busy;
    logic [2*MUL_W-1:0] mul_res;

    logic        ceil_neg;
    logic [15:0] ceil_mag;

    assign ceil_neg = (d_reg < 16'(HORIZON_Q));
    assign ceil_mag = ceil_neg ? (16'(HORIZON_Q) - d_reg) : (d_reg - 16'(HORIZON_Q));

    always_comb
    begin
        div_start    = (cmd.op == OP_CEIL);
        div_dividend = DIV_DW'(ceil_mag) * DIV_DW'(SCREEN_HEIGHT);
        div_divisor  = {d_reg, 1'b0};
    end

    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = num_reg[MUL_W-1:0];
        mul_b     = num_reg[MUL_W-1:0];
        if (cmd.op == OP_SQ)
        begin
            mul_start = 1'b1;
        end
        else if (cmd.op == OP_RHS)
        begin
            mul_start = 1'b1;
            mul_a     = len_reg[k_reg];
            mul_b     = MUL_W'(EDGE_COS2);
        end
    end

    rcr_div #(
        .DW (DIV_DW),
        .VW (DIV_VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    rcr_mul #(
        .W (MUL_W)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .busy   (mul_busy),
        .result (mul_res)
    );

    // Corner vectors of the hit cell for corner k
    logic [4:0]         cxk;
    logic [4:0]         cyk;
    logic signed [17:0] vx_w;
    logic signed [17:0] vy_w;

    assign cxk  = {1'b0, cx_reg} + {4'b0, k_reg[1]};
    assign cyk  = {1'b0, cy_reg} + {4'b0, k_reg[0]};
    assign vx_w = $signed({2'b0, cxk, 11'b0}) - $signed({3'b0, px_reg});
    assign vy_w = $signed({2'b0, cyk, 11'b0}) - $signed({3'b0, py_reg});

    // Shared signed 18x18 multiplier
    logic signed [17:0] ma;
    logic signed [17:0] mb;
    logic signed [35:0] mprod;
    logic signed [17:0] ex_w;
    logic signed [17:0] ey_w;
    logic signed [17:0] d_w;

    assign ex_w = {{2{ex_reg[15]}}, ex_reg};
    assign ey_w = {{2{ey_reg[15]}}, ey_reg};
    assign d_w  = $signed({2'b0, d_reg});

    always_comb
    begin
        ma = ex_w;
        mb = d_w;
        unique case (cmd.op)
            OP_MY:   begin ma = ey_w; mb = d_w;  end
            OP_SQX:  begin ma = vx_w; mb = vx_w; end
            OP_SQY:  begin ma = vy_w; mb = vy_w; end
            OP_NX:   begin ma = ex_w; mb = vx_w; end
            OP_NY:   begin ma = ey_w; mb = vy_w; end
            default: begin ma = ex_w; mb = d_w;  end
        endcase
    end

    assign mprod = ma * mb;

    // Offset trunc(prod / 16384) toward zero, then position and map cell
    logic signed [35:0] prod_adj;
    logic signed [35:0] prod_sh;
    logic signed [18:0] off_w;
    logic signed [18:0] posx_w;
    logic signed [18:0] posy_w;
    logic               exit_x;
    logic               exit_y;
    logic [3:0]         cxw;
    logic [3:0]         cyw;
    logic [31:0]        len_w;

    assign prod_adj = prod_reg + (prod_reg[35] ? 36'sd16383 : 36'sd0);
    assign prod_sh  = prod_adj >>> 14;
    assign off_w    = prod_sh[18:0];
    assign posx_w   = $signed({4'b0, px_reg}) + off_w;
    assign posy_w   = $signed({4'b0, py_reg}) + off_w;
    assign exit_x   = (posx_reg <= -19'sd2048) || (posx_reg >= 19'sd32768);
    assign exit_y   = (posy_w <= -19'sd2048) || (posy_w >= 19'sd32768);
    assign cxw      = posx_reg[18] ? 4'd0 : posx_reg[14:11];
    assign cyw      = posy_w[18] ? 4'd0 : posy_w[14:11];
    assign len_w    = acc_reg[31:0] + prod_reg[31:0];

    always_comb
    begin
        map_next = map_reg;
        px_next  = px_reg;
        py_next  = py_reg;
        pa_next  = pa_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_MAP0:         map_next[0 +: 64]   = cfg_data;
                CFG_MAP1:         map_next[64 +: 64]  = cfg_data;
                CFG_MAP2:         map_next[128 +: 64] = cfg_data;
                CFG_MAP3:         map_next[192 +: 64] = cfg_data;
                CFG_PLAYER_X:     px_next = cfg_data[14:0];
                CFG_PLAYER_Y:     py_next = cfg_data[14:0];
                CFG_PLAYER_ANGLE: pa_next = cfg_data[15:0];
                default:          map_next = map_reg;
            endcase
        end
    end

    always_comb
    begin
        col_next     = col_reg;
        ray_next     = ray_reg;
        rom_q_next   = sine_rom[rom_addr];
        ex_next      = ex_reg;
        ey_next      = ey_reg;
        d_next       = d_reg;
        prod_next    = prod_reg;
        acc_next     = acc_reg;
        num_next     = num_reg;
        posx_next    = posx_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        k_next       = k_reg;
        far_next     = far_reg;
        far_len_next = far_len_reg;
        len_next     = len_reg;
        lhs_next     = lhs_reg;
        edge_next    = edge_reg;
        neg_next     = neg_reg;
        nceil_next   = nceil_reg;
        y_next       = y_reg;
        unique case (cmd.op)
            OP_LOAD:  col_next = column;
            OP_RAY:   ray_next = pa_reg + col_ang[col_reg] + RAY_BIAS;
            OP_COS:   ex_next = rom_q_reg;
            OP_EY:
            begin
                ey_next   = rom_q_reg;
                d_next    = 16'(STEP_Q);
                edge_next = 1'b0;
            end
            OP_MX:    prod_next = mprod;
            OP_MY:
            begin
                posx_next = posx_w;
                prod_next = mprod;
            end
            OP_EXIT:  d_next = 16'(DEPTH_Q);
            OP_HIT:
            begin
                cx_next  = cxw;
                cy_next  = cyw;
                k_next   = 2'd0;
                far_next = 2'd0;
            end
            OP_STEP:  d_next = d_reg + 16'(STEP_Q);
            OP_SQX:   prod_next = mprod;
            OP_SQY, OP_NY:
            begin
                acc_next  = prod_reg;
                prod_next = mprod;
            end
            OP_LEN:
            begin
                len_next[k_reg] = len_w;
                // The later corner wins a tie for farthest
                if (k_reg == 2'd0 || len_w >= far_len_reg)
                begin
                    far_next     = k_reg;
                    far_len_next = len_w;
                end
                k_next = k_reg + 2'd1;
            end
            OP_NX:    prod_next = mprod;
            OP_NUM:   num_next = acc_reg + prod_reg;
            OP_NEXT:  k_next = k_reg + 2'd1;
            OP_RHS:   lhs_next = {mul_res[61:0], 2'b00};
            OP_EDGE:  edge_next = 1'b1;
            OP_CEIL:  neg_next = ceil_neg;
            OP_NCEIL:
            begin
                nceil_next = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
                y_next     = 6'd0;
            end
            OP_ROW:   y_next = y_reg + 6'd1;
            default:  y_next = y_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
            px_reg  <= PLAYER_X_RESET;
            py_reg  <= PLAYER_Y_RESET;
            pa_reg  <= '0;
        end
        else
        begin
            map_reg <= map_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
            pa_reg  <= pa_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        ray_reg     <= ray_next;
        rom_q_reg   <= rom_q_next;
        ex_reg      <= ex_next;
        ey_reg      <= ey_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        posx_reg    <= posx_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        k_reg       <= k_next;
        far_reg     <= far_next;
        far_len_reg <= far_len_next;
        len_reg     <= len_next;
        lhs_reg     <= lhs_next;
        edge_reg    <= edge_next;
        neg_reg     <= neg_next;
        nceil_reg   <= nceil_next;
        y_reg       <= y_next;
    end

    // Row shading
    logic signed [NW-1:0] ys;
    logic signed [NW-1:0] nceil_ext;
    logic signed [NW-1:0] nfloor_w;
    logic [6:0]           rem_w;
    logic [6:0]           shade;
    logic [6:0]           floor_ch;

    assign ys        = $signed({{(NW-6){1'b0}}, y_reg});
    assign nceil_ext = {nceil_reg[DIV_DW], nceil_reg};
    assign nfloor_w  = H_S - nceil_ext;
    assign rem_w     = 7'(SCREEN_HEIGHT) - {1'b0, y_reg};

    always_comb
    begin
        if (edge_reg)
            shade = CH_SPACE;
        else if (d_reg < 16'(NEAR_Q))
            shade = CH_TILDE;
        else if (d_reg < 16'(DEPTH_Q))
            shade = CH_MINUS;
        else
            shade = CH_SPACE;
    end

    always_comb
    begin
        priority if (8 * int'(rem_w) < SCREEN_HEIGHT)
            floor_ch = CH_HASH;
        else if (4 * int'(rem_w) < SCREEN_HEIGHT)
            floor_ch = CH_X;
        else if (8 * int'(rem_w) < 3 * SCREEN_HEIGHT)
            floor_ch = CH_DOT;
        else if (20 * int'(rem_w) < 9 * SCREEN_HEIGHT)
            floor_ch = CH_MINUS;
        else
            floor_ch = CH_SPACE;
    end

    always_comb
    begin
        priority if (ys <= nceil_ext)
            char_code = CH_SPACE;
        else if (ys <= nfloor_w)
            char_code = shade;
        else
            char_code = floor_ch;
    end

    assign column_echo   = col_reg;
    assign row           = y_reg;
    assign wall_distance = d_reg;
    assign last_row      = (y_reg == 6'(SCREEN_HEIGHT - 1));

    assign status.div_busy   = div_busy;
    assign status.mul_busy   = mul_busy;
    assign status.ray_exit   = exit_x || exit_y;
    assign status.wall       = map_reg[{cxw, cyw}];
    assign status.depth_done = (d_reg >= 16'(DEPTH_Q));
    assign status.k_last     = (k_reg == 2'd3);
    assign status.skip       = (num_reg <= 36'sd0) || (k_reg == far_reg);
    assign status.lhs_gt     = (lhs_reg > mul_res);
    assign status.out_last   = last_row;

endmodule

// File: sv/raycast_column_renderer_top.sv
// Top level of the raycast column renderer: controller, datapath and checks.
// Order of work: the ray direction from the accepted item, then the ray march
// (at most 160 steps), the corner test on a wall hit and the ceiling divide,
// then one row item per cycle while result_ready is high (SCREEN_HEIGHT rows).
// One column is cast at a time; a new column is taken only after its last row.
// Reset (rst_n, asynchronous, active low) empties the block and restores the map and viewer.
`timescale 1ns / 1ps

module raycast_column_renderer_top #(
    parameter int SCREEN_WIDTH     = rcr_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT    = rcr_pkg::DEFAULT_SCREEN_HEIGHT,
    parameter int SINE_TABLE_DEPTH = rcr_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           column_valid,
    output logic                           column_ready,
    input  logic [7:0]                     column,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [7:0]                     column_echo,
    output logic [5:0]                     row,
    output logic [6:0]                     char_code,
    output logic [15:0]                    wall_distance,
    output logic                           last_row
);
    import rcr_pkg::*;

    // The controller steps through the cast of one item; the datapath holds all
    // arithmetic, the sine and column angle tables, the ceiling divider and the
    // wide multiplier.
    cmd_t    cmd;
    status_t status;

    rcr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .column_valid (column_valid),
        .column_ready (column_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Row items are shown straight from datapath registers while the
    // controller holds the output state; each accepted item advances the row.
    rcr_dp #(
        .SCREEN_WIDTH     (SCREEN_WIDTH),
        .SCREEN_HEIGHT    (SCREEN_HEIGHT),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .column        (column),
        .column_echo   (column_echo),
        .row           (row),
        .char_code     (char_code),
        .wall_distance (wall_distance),
        .last_row      (last_row)
    );

    // A new column is never taken while rows of the previous one are still out.
    a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !column_ready)
        else $error("column accepted while rows are pending");

    // Rows of a column leave in order, one higher each time.
    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && !last_row) |=>
        (result_valid && row == $past(row) + 6'd1))
        else $error("row sequence broken");

    // After the bottom row the block is ready for the next column.
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && last_row) |=> column_ready)
        else $error("block not idle after last row");

    // An accepted column starts its cast rather than showing rows at once.
    a_no_early_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (column_valid && column_ready) |=> !result_valid)
        else $error("rows shown before the cast");

endmodule
